// File: hdl/ljpf_pkg.sv
// ---------------------------------------------------------------------------
// ljpf_pkg: shared types and constants for the Lennard-Jones pair force block
// Holds the request and result payload structs, the register indexes, the
// command and status structs that join the controller to the datapath, and
// the fixed widths of the arithmetic.
// ---------------------------------------------------------------------------
package ljpf_pkg;

	// Fixed field widths.
	localparam int POSITION_WIDTH = 16;
	localparam int BOX_W          = 16;
	localparam int CUT_W          = 20;
	localparam int CFG_W          = 20;
	localparam int OUT_W          = 32;

	// Displacement, magnitude and squared distance widths.
	localparam int D_W  = POSITION_WIDTH + 3;
	localparam int M_W  = POSITION_WIDTH + 2;
	localparam int R2_W = 2 * M_W + 2;

	// Reciprocal: floor(2^56 / r2) needs 57 quotient bits, one per step.
	localparam int Q_W       = 57;
	localparam int DIV_STEPS = Q_W;

	// Multiplier: 64 x 64 product from four 32 x 32 partial products.
	localparam int OP_W   = 64;
	localparam int HALF_W = 32;
	localparam int PROD_W = 128;

	localparam logic [31:0] FAR_LIMIT = 32'h0010_0000;
	localparam logic [OP_W-1:0] POW_CAP = 64'h7FFF_FFFF_FFFF_FFFF;

	localparam logic [BOX_W-1:0] BOX_RESET = 16'd30228;
	localparam logic [CUT_W-1:0] CUT_RESET = 20'd25600;

	// Configuration register indexes.
	typedef enum logic [0:0] {
		REG_BOX_LENGTH     = 1'b0,
		REG_CUTOFF_SQUARED = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [POSITION_WIDTH-1:0] center_x;
		logic [POSITION_WIDTH-1:0] center_y;
		logic [POSITION_WIDTH-1:0] center_z;
		logic [POSITION_WIDTH-1:0] neighbor_x;
		logic [POSITION_WIDTH-1:0] neighbor_y;
		logic [POSITION_WIDTH-1:0] neighbor_z;
		logic                      last_neighbor;
	} in_item_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] force_x;
		logic signed [OUT_W-1:0] force_y;
		logic signed [OUT_W-1:0] force_z;
		logic signed [OUT_W-1:0] pair_energy;
		logic                    saturated;
	} out_item_t;

	// Periodic image offset of one axis.
	typedef enum logic [1:0] {
		OFF_ZERO = 2'd0,
		OFF_NEG  = 2'd1,
		OFF_POS  = 2'd2
	} off_t;

	// Datapath operations.
	typedef enum logic [3:0] {
		OP_NONE      = 4'd0,
		OP_LOAD      = 4'd1,
		OP_AXIS      = 4'd2,
		OP_DIV_INIT  = 4'd3,
		OP_DIV_STEP  = 4'd4,
		OP_MUL_STEP  = 4'd5,
		OP_MUL_STORE = 4'd6,
		OP_ENERGY    = 4'd7,
		OP_EMIT      = 4'd8
	} op_t;

	// Multiplier job: one of the powers of s or a force term.
	typedef enum logic [2:0] {
		MS_S2    = 3'd0,
		MS_S3    = 3'd1,
		MS_S4    = 3'd2,
		MS_S6    = 3'd3,
		MS_S7    = 3'd4,
		MS_FORCE = 3'd5
	} msel_t;

	typedef struct packed {
		op_t        op;
		logic [1:0] axis;
		off_t       offset;
		msel_t      msel;
		logic [1:0] part;
	} cmd_t;

	typedef struct packed {
		logic skip;
		logic last;
		logic out_free;
	} sts_t;

endpackage

// File: hdl/ljpf_datapath.sv
// ---------------------------------------------------------------------------
// ljpf_datapath: arithmetic and storage of the pair force block
// Holds the configuration, the captured request, the displacement per axis,
// a bit-serial reciprocal unit, a shared 32 x 32 multiplier that builds 64 x 64
// products from its partial products, the saturating accumulators and the result
// register. Every arithmetic operation is selected by the controller's command.
// ---------------------------------------------------------------------------
module ljpf_datapath #(
	parameter int SUM_WIDTH = 40
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ljpf_pkg::cmd_t       cmd,
	output ljpf_pkg::sts_t       sts,
	input  ljpf_pkg::in_item_t   in_data,
	input  logic                 cfg_write,
	input  ljpf_pkg::reg_idx_t   cfg_index,
	input  logic [ljpf_pkg::CFG_W-1:0] cfg_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output ljpf_pkg::out_item_t  out_data
);

	localparam int D_W    = ljpf_pkg::D_W;
	localparam int M_W    = ljpf_pkg::M_W;
	localparam int R2_W   = ljpf_pkg::R2_W;
	localparam int Q_W    = ljpf_pkg::Q_W;
	localparam int OP_W   = ljpf_pkg::OP_W;
	localparam int HALF_W = ljpf_pkg::HALF_W;
	localparam int PROD_W = ljpf_pkg::PROD_W;
	localparam int PW     = ljpf_pkg::POSITION_WIDTH;
	localparam int OUT_W  = ljpf_pkg::OUT_W;

	localparam logic [SUM_WIDTH-1:0] ACC_MAX_S = {1'b0, {(SUM_WIDTH-1){1'b1}}};
	localparam logic [SUM_WIDTH-1:0] ACC_MIN_S = {1'b1, {(SUM_WIDTH-1){1'b0}}};
	localparam logic [OP_W-1:0]      ACC_MAX64 = OP_W'(ACC_MAX_S);

	// Saturating add; the top bit of the result flags a clip.
	function automatic logic [SUM_WIDTH:0] sat_add(
		input logic signed [SUM_WIDTH-1:0] a,
		input logic signed [SUM_WIDTH-1:0] b
	);
		logic [SUM_WIDTH:0] w;
		logic [SUM_WIDTH:0] r;
		w = {a[SUM_WIDTH-1], a} + {b[SUM_WIDTH-1], b};
		if (w[SUM_WIDTH] != w[SUM_WIDTH-1]) begin
			r = {1'b1, (w[SUM_WIDTH] ? ACC_MIN_S : ACC_MAX_S)};
		end else begin
			r = {1'b0, w[SUM_WIDTH-1:0]};
		end
		return r;
	endfunction

	// Clip to the 32-bit output range; the top bit flags a clip.
	function automatic logic [OUT_W:0] clip32(input logic signed [SUM_WIDTH-1:0] v);
		logic        hit;
		logic [OUT_W:0] r;
		hit = !((&v[SUM_WIDTH-1:OUT_W-1]) || !(|v[SUM_WIDTH-1:OUT_W-1]));
		if (hit) begin
			r = {1'b1, (v[SUM_WIDTH-1] ? 32'h8000_0000 : 32'h7FFF_FFFF)};
		end else begin
			r = {1'b0, v[OUT_W-1:0]};
		end
		return r;
	endfunction

	// Configuration and request registers.
	logic [ljpf_pkg::BOX_W-1:0] box_q;
	logic [ljpf_pkg::CUT_W-1:0] cut_q;
	ljpf_pkg::in_item_t         in_q;

	// Per-image state.
	logic signed [D_W-1:0] d_q [3];
	logic [M_W-1:0]        dmag_q [3];
	logic [R2_W-1:0]       r2_q;
	logic                  far_q;
	logic [R2_W-1:0]       rem_q;
	logic [Q_W-1:0]        quo_q;
	logic                  div_first_q;
	logic [PROD_W-1:0]     acc_q;
	logic [OP_W-1:0]       s2_q, s3_q, s4_q, s6_q, s7_q;
	logic                  o2_q, o3_q, o4_q, o6_q, o7_q;
	logic [OP_W-1:0]       gmag_q;
	logic                  gneg_q;
	logic                  fhuge_q;

	// Accumulators and result.
	logic signed [SUM_WIDTH-1:0] sum_f_q [3];
	logic signed [SUM_WIDTH-1:0] sum_e_q;
	logic                        clip_q;
	ljpf_pkg::out_item_t         out_q;
	logic                        out_valid_q;

	// Displacement of the selected axis for the current image.
	logic [PW-1:0]         c_sel, n_sel;
	logic signed [D_W-1:0] diff, d_new;
	logic [D_W-1:0]        magw;
	logic [M_W-1:0]        m_new;
	logic [2*M_W-1:0]      sq;
	logic                  far_new;

	always_comb begin
		case (cmd.axis)
			2'd0: begin
				c_sel = in_q.center_x;
				n_sel = in_q.neighbor_x;
			end
			2'd1: begin
				c_sel = in_q.center_y;
				n_sel = in_q.neighbor_y;
			end
			default: begin
				c_sel = in_q.center_z;
				n_sel = in_q.neighbor_z;
			end
		endcase
		diff = $signed({{(D_W-PW){1'b0}}, c_sel}) - $signed({{(D_W-PW){1'b0}}, n_sel});
		case (cmd.offset)
			ljpf_pkg::OFF_NEG: d_new = diff + $signed({{(D_W-ljpf_pkg::BOX_W){1'b0}}, box_q});
			ljpf_pkg::OFF_POS: d_new = diff - $signed({{(D_W-ljpf_pkg::BOX_W){1'b0}}, box_q});
			default:           d_new = diff;
		endcase
		magw    = d_new[D_W-1] ? D_W'(-d_new) : D_W'(d_new);
		m_new   = magw[M_W-1:0];
		sq      = m_new * m_new;
		far_new = 32'(magw) > ljpf_pkg::FAR_LIMIT;
	end

	// Image filter: too far, coincident or beyond the cutoff.
	always_comb begin
		sts.skip = far_q || (r2_q == '0) ||
			(64'(r2_q) > 64'({cut_q, 12'h000}));
		sts.last     = in_q.last_neighbor;
		sts.out_free = !out_valid_q || !out_stall;
	end

	// Restoring division step of 2^56 / r2.
	logic [R2_W:0] trial;
	logic          ge;
	logic [R2_W:0] trial_sub;
	logic [OP_W-1:0] s_val;

	always_comb begin
		trial     = {rem_q, div_first_q};
		ge        = trial >= {1'b0, r2_q};
		trial_sub = trial - {1'b0, r2_q};
		s_val     = OP_W'(quo_q);
	end

	// Operand selection and one partial product of the shared multiplier.
	logic [OP_W-1:0]     op_a, op_b;
	logic [HALF_W-1:0]   half_a, half_b;
	logic [2*HALF_W-1:0] pp;
	logic [6:0]          pp_shift;

	always_comb begin
		case (cmd.msel)
			ljpf_pkg::MS_S2: begin
				op_a = s_val;
				op_b = s_val;
			end
			ljpf_pkg::MS_S3: begin
				op_a = s2_q;
				op_b = s_val;
			end
			ljpf_pkg::MS_S4: begin
				op_a = s2_q;
				op_b = s2_q;
			end
			ljpf_pkg::MS_S6: begin
				op_a = s3_q;
				op_b = s3_q;
			end
			ljpf_pkg::MS_S7: begin
				op_a = s6_q;
				op_b = s_val;
			end
			default: begin
				op_a = OP_W'(dmag_q[cmd.axis]);
				op_b = gmag_q;
			end
		endcase
		half_a   = cmd.part[1] ? op_a[OP_W-1:HALF_W] : op_a[HALF_W-1:0];
		half_b   = cmd.part[0] ? op_b[OP_W-1:HALF_W] : op_b[HALF_W-1:0];
		pp       = half_a * half_b;
		pp_shift = {cmd.part[1] & cmd.part[0], cmd.part[1] ^ cmd.part[0], 5'b00000};
	end

	// Product scaling and saturation.
	logic [PROD_W-1:0] shifted;
	logic [OP_W-1:0]   cap;
	logic              over;
	logic [OP_W-1:0]   res;

	always_comb begin
		if (cmd.msel == ljpf_pkg::MS_FORCE) begin
			shifted = acc_q >> 28;
			cap     = ACC_MAX64;
		end else begin
			shifted = acc_q >> 32;
			cap     = ljpf_pkg::POW_CAP;
		end
		over = shifted > PROD_W'(cap);
		res  = over ? cap : shifted[OP_W-1:0];
	end

	// Force term of the selected axis and its accumulation.
	logic                        f_dneg, f_dz, f_neg, f_clip;
	logic [SUM_WIDTH-1:0]        f_mag;
	logic signed [SUM_WIDTH-1:0] f_term;
	logic [SUM_WIDTH:0]          f_sum;

	always_comb begin
		f_dneg = d_q[cmd.axis][D_W-1];
		f_dz   = d_q[cmd.axis] == '0;
		f_mag  = fhuge_q ? ACC_MAX_S : res[SUM_WIDTH-1:0];
		f_neg  = fhuge_q ? f_dneg : (f_dneg ^ gneg_q);
		if (f_dz) begin
			f_term = '0;
		end else begin
			f_term = f_neg ? -$signed(f_mag) : $signed(f_mag);
		end
		f_clip = !f_dz && (fhuge_q || over);
		f_sum  = sat_add(sum_f_q[cmd.axis], f_term);
	end

	// Energy term and force factor.
	logic                        ehuge;
	logic [OP_W-1:0]             ediff, em;
	logic                        em_clip;
	logic signed [SUM_WIDTH-1:0] e_term;
	logic [SUM_WIDTH:0]          e_sum;
	logic [OP_W-1:0]             s4h;

	always_comb begin
		ehuge   = o2_q || o3_q || o6_q;
		ediff   = (s6_q >= s3_q) ? (s6_q - s3_q) : (s3_q - s6_q);
		em      = ediff >> 16;
		em_clip = em > ACC_MAX64;
		if (ehuge) begin
			e_term = $signed(ACC_MAX_S);
		end else if (em_clip) begin
			e_term = (s6_q >= s3_q) ? $signed(ACC_MAX_S) : -$signed(ACC_MAX_S);
		end else begin
			e_term = (s6_q >= s3_q) ? $signed(em[SUM_WIDTH-1:0]) :
				-$signed(em[SUM_WIDTH-1:0]);
		end
		e_sum = sat_add(sum_e_q, e_term);
		s4h   = s4_q >> 1;
	end

	// Output clipping.
	logic [OUT_W:0] cx, cy, cz, ce;

	always_comb begin
		cx = clip32(sum_f_q[0]);
		cy = clip32(sum_f_q[1]);
		cz = clip32(sum_f_q[2]);
		ce = clip32(sum_e_q);
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_q <= ljpf_pkg::BOX_RESET;
			cut_q <= ljpf_pkg::CUT_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				ljpf_pkg::REG_BOX_LENGTH:     box_q <= cfg_data[ljpf_pkg::BOX_W-1:0];
				ljpf_pkg::REG_CUTOFF_SQUARED: cut_q <= cfg_data[ljpf_pkg::CUT_W-1:0];
				default: ;
			endcase
		end
	end

	// Working registers of one image.
	always_ff @(posedge clk) begin
		case (cmd.op)
			ljpf_pkg::OP_LOAD: begin
				in_q <= in_data;
			end
			ljpf_pkg::OP_AXIS: begin
				d_q[cmd.axis]    <= d_new;
				dmag_q[cmd.axis] <= m_new;
				if (cmd.axis == 2'd0) begin
					r2_q  <= R2_W'(sq);
					far_q <= far_new;
				end else begin
					r2_q  <= r2_q + R2_W'(sq);
					far_q <= far_q | far_new;
				end
			end
			ljpf_pkg::OP_DIV_INIT: begin
				rem_q       <= '0;
				quo_q       <= '0;
				div_first_q <= 1'b1;
			end
			ljpf_pkg::OP_DIV_STEP: begin
				rem_q       <= ge ? trial_sub[R2_W-1:0] : trial[R2_W-1:0];
				quo_q       <= {quo_q[Q_W-2:0], ge};
				div_first_q <= 1'b0;
			end
			ljpf_pkg::OP_MUL_STEP: begin
				if (cmd.part == 2'd0) begin
					acc_q <= PROD_W'(pp);
				end else begin
					acc_q <= acc_q + (PROD_W'(pp) << pp_shift);
				end
			end
			ljpf_pkg::OP_MUL_STORE: begin
				case (cmd.msel)
					ljpf_pkg::MS_S2: begin
						s2_q <= res;
						o2_q <= over;
					end
					ljpf_pkg::MS_S3: begin
						s3_q <= res;
						o3_q <= over;
					end
					ljpf_pkg::MS_S4: begin
						s4_q <= res;
						o4_q <= over;
					end
					ljpf_pkg::MS_S6: begin
						s6_q <= res;
						o6_q <= over;
					end
					ljpf_pkg::MS_S7: begin
						s7_q <= res;
						o7_q <= over;
					end
					default: ;
				endcase
			end
			ljpf_pkg::OP_ENERGY: begin
				fhuge_q <= ehuge || o4_q || o7_q;
				gneg_q  <= s7_q < s4h;
				gmag_q  <= (s7_q < s4h) ? (s4h - s7_q) : (s7_q - s4h);
			end
			default: ;
		endcase
	end

	// Accumulators, clip flag and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_f_q[0]  <= '0;
			sum_f_q[1]  <= '0;
			sum_f_q[2]  <= '0;
			sum_e_q     <= '0;
			clip_q      <= 1'b0;
			out_q       <= '0;
		end else begin
			case (cmd.op)
				ljpf_pkg::OP_MUL_STORE: begin
					if (cmd.msel == ljpf_pkg::MS_FORCE) begin
						sum_f_q[cmd.axis] <= f_sum[SUM_WIDTH-1:0];
						clip_q <= clip_q | f_clip | f_sum[SUM_WIDTH];
					end
				end
				ljpf_pkg::OP_ENERGY: begin
					sum_e_q <= e_sum[SUM_WIDTH-1:0];
					clip_q  <= clip_q | ehuge | em_clip | e_sum[SUM_WIDTH];
				end
				ljpf_pkg::OP_EMIT: begin
					out_q.force_x     <= cx[OUT_W-1:0];
					out_q.force_y     <= cy[OUT_W-1:0];
					out_q.force_z     <= cz[OUT_W-1:0];
					out_q.pair_energy <= ce[OUT_W-1:0];
					out_q.saturated   <= clip_q | cx[OUT_W] | cy[OUT_W] | cz[OUT_W] | ce[OUT_W];
					sum_f_q[0]  <= '0;
					sum_f_q[1]  <= '0;
					sum_f_q[2]  <= '0;
					sum_e_q     <= '0;
					clip_q      <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// Result valid: set by a hand-off, cleared once the result is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == ljpf_pkg::OP_EMIT) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// File: hdl/ljpf_controller.sv
// ---------------------------------------------------------------------------
// ljpf_controller: sequencer of the pair force block
// Walks the 27 periodic images of one request: the axis displacements,
// a filter check and, if in range, the reciprocal, five powers, the energy
// term and three force terms, then the result hand-off on the last neighbor.
// ---------------------------------------------------------------------------
module ljpf_controller (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  ljpf_pkg::sts_t sts,
	output ljpf_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_AXIS,
		S_CHECK,
		S_DIV,
		S_MUL,
		S_ENERGY,
		S_NEXT,
		S_EMIT
	} state_t;

	state_t          state_q;
	logic [1:0]      ix_q, iy_q, iz_q;
	logic [1:0]      axis_q;
	logic [5:0]      div_cnt_q;
	ljpf_pkg::msel_t msel_q;
	logic [2:0]      part_q;

	// Image counter value to offset code.
	function automatic ljpf_pkg::off_t off_code(input logic [1:0] v);
		ljpf_pkg::off_t r;
		case (v)
			2'd1:    r = ljpf_pkg::OFF_NEG;
			2'd2:    r = ljpf_pkg::OFF_POS;
			default: r = ljpf_pkg::OFF_ZERO;
		endcase
		return r;
	endfunction

	// Command decode.
	always_comb begin
		cmd.op   = ljpf_pkg::OP_NONE;
		cmd.axis = axis_q;
		cmd.msel = msel_q;
		cmd.part = part_q[1:0];
		case (axis_q)
			2'd0:    cmd.offset = off_code(ix_q);
			2'd1:    cmd.offset = off_code(iy_q);
			default: cmd.offset = off_code(iz_q);
		endcase
		case (state_q)
			S_IDLE:   cmd.op = in_valid ? ljpf_pkg::OP_LOAD : ljpf_pkg::OP_NONE;
			S_AXIS:   cmd.op = ljpf_pkg::OP_AXIS;
			S_CHECK:  cmd.op = sts.skip ? ljpf_pkg::OP_NONE : ljpf_pkg::OP_DIV_INIT;
			S_DIV:    cmd.op = ljpf_pkg::OP_DIV_STEP;
			S_MUL:    cmd.op = (part_q == 3'd4) ? ljpf_pkg::OP_MUL_STORE :
				ljpf_pkg::OP_MUL_STEP;
			S_ENERGY: cmd.op = ljpf_pkg::OP_ENERGY;
			S_EMIT:   cmd.op = sts.out_free ? ljpf_pkg::OP_EMIT : ljpf_pkg::OP_NONE;
			default:  cmd.op = ljpf_pkg::OP_NONE;
		endcase
	end

	assign in_stall = state_q != S_IDLE;

	// State and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			ix_q      <= 2'd0;
			iy_q      <= 2'd0;
			iz_q      <= 2'd0;
			axis_q    <= 2'd0;
			div_cnt_q <= 6'd0;
			msel_q    <= ljpf_pkg::MS_S2;
			part_q    <= 3'd0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						ix_q    <= 2'd0;
						iy_q    <= 2'd0;
						iz_q    <= 2'd0;
						axis_q  <= 2'd0;
						state_q <= S_AXIS;
					end
				end
				S_AXIS: begin
					if (axis_q == 2'd2) begin
						axis_q  <= 2'd0;
						state_q <= S_CHECK;
					end else begin
						axis_q <= axis_q + 2'd1;
					end
				end
				S_CHECK: begin
					div_cnt_q <= 6'd0;
					state_q   <= sts.skip ? S_NEXT : S_DIV;
				end
				S_DIV: begin
					if (div_cnt_q == 6'(ljpf_pkg::DIV_STEPS - 1)) begin
						msel_q  <= ljpf_pkg::MS_S2;
						part_q  <= 3'd0;
						state_q <= S_MUL;
					end else begin
						div_cnt_q <= div_cnt_q + 6'd1;
					end
				end
				S_MUL: begin
					if (part_q == 3'd4) begin
						part_q <= 3'd0;
						case (msel_q)
							ljpf_pkg::MS_S2: msel_q <= ljpf_pkg::MS_S3;
							ljpf_pkg::MS_S3: msel_q <= ljpf_pkg::MS_S4;
							ljpf_pkg::MS_S4: msel_q <= ljpf_pkg::MS_S6;
							ljpf_pkg::MS_S6: msel_q <= ljpf_pkg::MS_S7;
							ljpf_pkg::MS_S7: state_q <= S_ENERGY;
							default: begin
								if (axis_q == 2'd2) begin
									axis_q  <= 2'd0;
									state_q <= S_NEXT;
								end else begin
									axis_q <= axis_q + 2'd1;
								end
							end
						endcase
					end else begin
						part_q <= part_q + 3'd1;
					end
				end
				S_ENERGY: begin
					msel_q  <= ljpf_pkg::MS_FORCE;
					axis_q  <= 2'd0;
					part_q  <= 3'd0;
					state_q <= S_MUL;
				end
				S_NEXT: begin
					axis_q <= 2'd0;
					if (iz_q != 2'd2) begin
						iz_q    <= iz_q + 2'd1;
						state_q <= S_AXIS;
					end else if (iy_q != 2'd2) begin
						iz_q    <= 2'd0;
						iy_q    <= iy_q + 2'd1;
						state_q <= S_AXIS;
					end else if (ix_q != 2'd2) begin
						iz_q    <= 2'd0;
						iy_q    <= 2'd0;
						ix_q    <= ix_q + 2'd1;
						state_q <= S_AXIS;
					end else begin
						state_q <= sts.last ? S_EMIT : S_IDLE;
					end
				end
				S_EMIT: begin
					if (sts.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: hdl/lennard_jones_pair_force.sv
// ---------------------------------------------------------------------------
// lennard_jones_pair_force: Lennard-Jones force and energy over periodic images
// Each request is one center/neighbor pair. All 27 images are visited in turn;
// a skipped image runs only the displacement, the check and the advance, a
// used one also 57 reciprocal steps, 8 products and the energy term. A new
// request is taken only once every image of the last one is done; a last
// neighbor adds a hand-off, held while an earlier result waits. The bit-serial
// reciprocal and the shared 32 x 32 multiplier set the time a request takes.
// A result is registered in that hand-off, once any earlier result is taken.
// Reset clears the sums, the clip flag and the result valid, and loads the
// register defaults; no clearing pass is needed.
// ---------------------------------------------------------------------------
module lennard_jones_pair_force #(
	parameter int SUM_WIDTH = 40
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  ljpf_pkg::in_item_t             in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output ljpf_pkg::out_item_t            out_data,
	input  logic                           cfg_write,
	input  ljpf_pkg::reg_idx_t             cfg_index,
	input  logic [ljpf_pkg::CFG_W-1:0]     cfg_data
);

	ljpf_pkg::cmd_t cmd;
	ljpf_pkg::sts_t sts;

	// Sequencer.
	ljpf_controller u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Arithmetic and storage.
	ljpf_datapath #(
		.SUM_WIDTH (SUM_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (in_data),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

// File: hdl/ljpf_checker.sv
// ---------------------------------------------------------------------------
// ljpf_checker: port-level checks of the pair force block
// Watches the request and result handshakes of the top level over time.
// ---------------------------------------------------------------------------
module ljpf_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall
);

	// A waiting result is held until taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// One request at a time: the block is busy right after an accept.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request accepted while previous one in flight");

	// A new result appears only as the block finishes its request.
	a_result_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !in_stall)
		else $error("result raised while still working");

	// A new result follows a busy cycle.
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result raised without a request in progress");

endmodule

bind lennard_jones_pair_force ljpf_checker u_ljpf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall)
);

// File: verif/lennard_jones_pair_force_test.sv
// ---------------------------------------------------------------------------
// lennard_jones_pair_force_test: self-checking bench for the pair force block
// Drives center/neighbor requests through the valid/stall handshake with
// random idling on both sides, predicts every result with a scoreboard that
// recomputes the 27-image fixed-point sums, and walks several register
// settings, the extremes among them.
// ---------------------------------------------------------------------------
module lennard_jones_pair_force_test;

	localparam longint ACC_MAX = (64'sd1 <<< 39) - 1;
	localparam longint ACC_MIN = -ACC_MAX - 1;
	localparam longint CYCLE_LIMIT = 40_000_000;
	localparam int SETTLE_CYCLES = 3000;
	localparam int HOLD_CYCLES = 6000;

	// Predicts the summed force and energy and holds the results still due.
	class force_scoreboard;
		longint box_len;
		longint cut_sq;
		longint acc_fx, acc_fy, acc_fz, acc_en;
		bit clip;
		ljpf_pkg::out_item_t due[$];
		int mismatches;

		function new();
			box_len = ljpf_pkg::BOX_RESET;
			cut_sq = ljpf_pkg::CUT_RESET;
			acc_fx = 0; acc_fy = 0; acc_fz = 0; acc_en = 0;
			clip = 0;
			mismatches = 0;
		endfunction

		function void set_reg(ljpf_pkg::reg_idx_t idx, logic [ljpf_pkg::CFG_W-1:0] val);
			if (idx == ljpf_pkg::REG_BOX_LENGTH)
				box_len = val[ljpf_pkg::BOX_W-1:0];
			else
				cut_sq = val[ljpf_pkg::CUT_W-1:0];
		endfunction

		// Product shifted down and held at the cap.
		function bit [63:0] mul_sat(bit [63:0] a, bit [63:0] b, int sh, bit [63:0] cap,
				inout bit over);
			bit [127:0] p;
			p = {64'd0, a} * {64'd0, b};
			p = p >> sh;
			if (p > {64'd0, cap}) begin
				over = 1;
				return cap;
			end
			return p[63:0];
		endfunction

		function longint acc_add(longint a, longint b);
			if (b > 0 && a > ACC_MAX - b) begin
				clip = 1;
				return ACC_MAX;
			end
			if (b < 0 && a < ACC_MIN - b) begin
				clip = 1;
				return ACC_MIN;
			end
			return a + b;
		endfunction

		function logic signed [31:0] to_out(longint v);
			if (v > 64'sd2147483647) begin
				v = 64'sd2147483647;
				clip = 1;
			end
			if (v < -64'sd2147483648) begin
				v = -64'sd2147483648;
				clip = 1;
			end
			return v[31:0];
		endfunction

		function longint force_of(longint d, bit huge, bit [63:0] gmag, bit gneg);
			bit [63:0] dmag;
			bit over;
			longint t;
			over = 0;
			if (d == 0)
				return 0;
			dmag = (d < 0) ? -d : d;
			if (huge) begin
				clip = 1;
				return (d < 0) ? -ACC_MAX : ACC_MAX;
			end
			t = mul_sat(dmag, gmag, 28, ACC_MAX, over);
			if (over)
				clip = 1;
			return ((d < 0) != gneg) ? -t : t;
		endfunction

		// One periodic image of the neighbor.
		function void add_image(longint c[3], longint n[3], longint ox, longint oy,
				longint oz);
			longint d[3];
			longint off[3];
			bit [63:0] m, r2, s, s2, s3, s4, s6, s7, s4h, gmag, em;
			bit o2, o3, o4, o6, o7, ehuge, fhuge, gneg;
			longint e;
			off[0] = ox; off[1] = oy; off[2] = oz;
			r2 = 0;
			o2 = 0; o3 = 0; o4 = 0; o6 = 0; o7 = 0;
			for (int a = 0; a < 3; a++) begin
				d[a] = c[a] - n[a] - off[a] * box_len;
				m = (d[a] < 0) ? -d[a] : d[a];
				if (m > 64'd1048576)
					return;
				r2 += m * m;
			end
			if (r2 == 0 || r2 > (cut_sq << 12))
				return;
			s = (64'd1 << 56) / r2;
			s2 = mul_sat(s, s, 32, ljpf_pkg::POW_CAP, o2);
			s3 = mul_sat(s2, s, 32, ljpf_pkg::POW_CAP, o3);
			s4 = mul_sat(s2, s2, 32, ljpf_pkg::POW_CAP, o4);
			s6 = mul_sat(s3, s3, 32, ljpf_pkg::POW_CAP, o6);
			s7 = mul_sat(s6, s, 32, ljpf_pkg::POW_CAP, o7);
			ehuge = o2 || o3 || o6;
			fhuge = ehuge || o4 || o7;
			if (ehuge) begin
				clip = 1;
				e = ACC_MAX;
			end else begin
				em = ((s6 >= s3) ? s6 - s3 : s3 - s6) >> 16;
				if (em > ACC_MAX) begin
					em = ACC_MAX;
					clip = 1;
				end
				e = (s6 >= s3) ? longint'(em) : -longint'(em);
			end
			acc_en = acc_add(acc_en, e);
			s4h = s4 >> 1;
			gneg = s7 < s4h;
			gmag = gneg ? s4h - s7 : s7 - s4h;
			acc_fx = acc_add(acc_fx, force_of(d[0], fhuge, gmag, gneg));
			acc_fy = acc_add(acc_fy, force_of(d[1], fhuge, gmag, gneg));
			acc_fz = acc_add(acc_fz, force_of(d[2], fhuge, gmag, gneg));
		endfunction

		// Accepted request: accumulate all images, queue a result on a last neighbor.
		function void note_request(ljpf_pkg::in_item_t it);
			longint c[3], n[3];
			longint offs[3];
			ljpf_pkg::out_item_t r;
			offs[0] = 0; offs[1] = -1; offs[2] = 1;
			c[0] = it.center_x; c[1] = it.center_y; c[2] = it.center_z;
			n[0] = it.neighbor_x; n[1] = it.neighbor_y; n[2] = it.neighbor_z;
			for (int ix = 0; ix < 3; ix++)
				for (int iy = 0; iy < 3; iy++)
					for (int iz = 0; iz < 3; iz++)
						add_image(c, n, offs[ix], offs[iy], offs[iz]);
			if (!it.last_neighbor)
				return;
			r.force_x = to_out(acc_fx);
			r.force_y = to_out(acc_fy);
			r.force_z = to_out(acc_fz);
			r.pair_energy = to_out(acc_en);
			r.saturated = clip;
			due.push_back(r);
			acc_fx = 0; acc_fy = 0; acc_fz = 0; acc_en = 0;
			clip = 0;
		endfunction

		function void check_result(ljpf_pkg::out_item_t got);
			ljpf_pkg::out_item_t want;
			if (due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: %p", got);
				return;
			end
			want = due.pop_front();
			if (got.force_x !== want.force_x || got.force_y !== want.force_y ||
					got.force_z !== want.force_z || got.pair_energy !== want.pair_energy ||
					got.saturated !== want.saturated) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result mismatch: expected %p, got %p", want, got);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	ljpf_pkg::in_item_t in_data;
	logic out_valid;
	logic out_stall = 1'b0;
	ljpf_pkg::out_item_t out_data;
	logic cfg_write;
	ljpf_pkg::reg_idx_t cfg_index;
	logic [ljpf_pkg::CFG_W-1:0] cfg_data;

	force_scoreboard sb;
	bit send_gaps;
	bit recv_gaps;
	bit hold_tag = 1'b0;
	bit hold_seen = 1'b0;
	int hold_cycles = 0;
	longint cycles = 0;

	lennard_jones_pair_force uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial clk = 0;
	always #10 clk = ~clk;

	// Handshakes are sampled mid-cycle, where the driven values are settled.
	always @(negedge clk) begin
		if (arst_n && in_valid && !in_stall)
			sb.note_request(in_data);
		if (arst_n && out_valid && !out_stall)
			sb.check_result(out_data);
	end

	// Receiver: random stalls, or a counted hold-off when one is requested.
	always @(posedge clk) begin
		if (hold_tag != hold_seen) begin
			hold_seen <= hold_tag;
			hold_cycles <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= recv_gaps && ($urandom_range(99) < 29);
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic send_request(ljpf_pkg::in_item_t it);
		bit taken;
		while (send_gaps && $urandom_range(99) < 29) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
	endtask

	task automatic write_reg(ljpf_pkg::reg_idx_t idx, logic [ljpf_pkg::CFG_W-1:0] val);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		sb.set_reg(idx, val);
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	// Sender pause until every expected result is back, plus time to settle.
	task automatic drain();
		@(posedge clk);
		in_valid <= 1'b0;
		while (sb.due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic ljpf_pkg::in_item_t make_pair(logic [15:0] cx, logic [15:0] cy,
			logic [15:0] cz, logic [15:0] nx, logic [15:0] ny, logic [15:0] nz, logic last);
		ljpf_pkg::in_item_t it;
		it.center_x = cx; it.center_y = cy; it.center_z = cz;
		it.neighbor_x = nx; it.neighbor_y = ny; it.neighbor_z = nz;
		it.last_neighbor = last;
		return it;
	endfunction

	// Mostly close pairs, some across the box edge, some anywhere.
	function automatic ljpf_pkg::in_item_t random_pair(bit force_last);
		ljpf_pkg::in_item_t it;
		int mode;
		logic [15:0] c[3], n[3];
		int span;
		mode = $urandom_range(99);
		span = $urandom_range(3) == 0 ? 600 : 12000;
		for (int a = 0; a < 3; a++) begin
			c[a] = 16'($urandom);
			if (mode < 65)
				n[a] = 16'(int'(c[a]) + int'($urandom_range(2 * span)) - span);
			else if (mode < 82)
				n[a] = 16'(longint'(c[a]) + ($urandom_range(1) ? sb.box_len : -sb.box_len)
					+ longint'($urandom_range(2 * span)) - span);
			else
				n[a] = 16'($urandom);
		end
		it = make_pair(c[0], c[1], c[2], n[0], n[1], n[2],
			force_last || ($urandom_range(3) == 0));
		return it;
	endfunction

	task automatic random_phase(int count);
		for (int i = 0; i < count; i++)
			send_request(random_pair(i == count - 1));
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_write = 1'b0;
		cfg_index = ljpf_pkg::REG_BOX_LENGTH;
		cfg_data = '0;
		send_gaps = 1;
		recv_gaps = 1;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed requests with the reset register values.
		send_request(make_pair(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1));
		send_request(make_pair(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1));
		// Coincident center and neighbor, then one LSB apart for huge powers.
		send_request(make_pair(16'h1234, 16'h5678, 16'h9ABC, 16'h1234, 16'h5678, 16'h9ABC, 0));
		send_request(make_pair(16'h1234, 16'h5678, 16'h9ABC, 16'h1235, 16'h5678, 16'h9ABC, 1));
		send_request(make_pair(16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0));
		send_request(make_pair(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 1));
		// Distances near 1, 0.875, 1.5 and the cutoff, accumulated over neighbors.
		send_request(make_pair(16'h4000, 16'h4000, 16'h4000, 16'h5000, 16'h4000, 16'h4000, 0));
		send_request(make_pair(16'h4000, 16'h4000, 16'h4000, 16'h4000, 16'h3200, 16'h4000, 0));
		send_request(make_pair(16'h4000, 16'h4000, 16'h4000, 16'h4000, 16'h4000, 16'h5800, 0));
		send_request(make_pair(16'h4000, 16'h4000, 16'h4000, 16'h6800, 16'h4000, 16'h4000, 1));
		// A neighbor seen only across the box edge.
		send_request(make_pair(16'h0100, 16'h0100, 16'h0100, 16'h7514, 16'h0100, 16'h0100, 1));
		// Many close neighbors summed before one result.
		for (int i = 0; i < 6; i++)
			send_request(make_pair(16'h8000, 16'h8000, 16'h8000,
				16'h8000 + 16'(i * 40 + 1), 16'h8000, 16'h8000, i == 5));
		drain();

		// Random requests with the reset values; a long receiver hold-off first.
		hold_tag = ~hold_tag;
		random_phase(400);
		// Stretch with no idling on either side.
		send_gaps = 0;
		recv_gaps = 0;
		random_phase(200);
		send_gaps = 1;
		recv_gaps = 1;
		drain();

		// Box edge zero and widest cutoff: all images fall on one point.
		write_reg(ljpf_pkg::REG_BOX_LENGTH, 20'd0);
		write_reg(ljpf_pkg::REG_CUTOFF_SQUARED, 20'hFFFFF);
		send_request(make_pair(16'h2000, 16'h2000, 16'h2000, 16'h2000, 16'h2000, 16'h2000, 1));
		send_request(make_pair(16'h2000, 16'h2000, 16'h2000, 16'h2001, 16'h2000, 16'h2000, 1));
		random_phase(60);
		drain();

		// Widest box and zero cutoff: nothing in range.
		write_reg(ljpf_pkg::REG_BOX_LENGTH, 20'hFFFF);
		write_reg(ljpf_pkg::REG_CUTOFF_SQUARED, 20'd0);
		random_phase(150);
		drain();

		// Widest box with a wide cutoff.
		write_reg(ljpf_pkg::REG_CUTOFF_SQUARED, 20'h40000);
		random_phase(150);
		drain();

		// Random settings.
		for (int p = 0; p < 4; p++) begin
			write_reg(ljpf_pkg::REG_BOX_LENGTH, 20'($urandom_range(65535)));
			write_reg(ljpf_pkg::REG_CUTOFF_SQUARED, 20'($urandom_range(65535)));
			random_phase(100);
			drain();
		end

		// Back to small boxes and the default cutoff.
		write_reg(ljpf_pkg::REG_BOX_LENGTH, 20'd8192);
		write_reg(ljpf_pkg::REG_CUTOFF_SQUARED, 20'd25600);
		random_phase(170);
		drain();

		if (sb.mismatches == 0 && sb.due.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
